[hdl/mfp_pkg.sv]
// Shared types and constants for the mode finder with percentage.
// No dependencies; every other file in hdl/ imports this package.
package mfp_pkg;

   localparam int VALUE_W = 32;   // element width on the ports and in the store
   localparam int COUNT_W = 9;    // mode_count field width
   localparam int PCT_W   = 15;   // percent_q8 field width

   // 100 percent scaled by 2^8 fraction bits
   localparam int PCT_SCALE_Q8 = 100 * 256;
   localparam int PCT_SCALE_W  = $clog2(PCT_SCALE_Q8 + 1);

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic                      last;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] mode_value;
      logic [COUNT_W-1:0]        mode_count;
      logic [PCT_W-1:0]          percent_q8;
      logic                      overflow;
   } rsp_type;

   // status returned by the divider
   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

[hdl/mfp_store.sv]
// Element store: single write port, single read port with registered data.
// Depends on mfp_pkg for the element width.
module mfp_store #(
   parameter int DEPTH = 256,
   parameter int AW    = 8
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [AW-1:0]               wr_addr,
   input  logic [mfp_pkg::VALUE_W-1:0] wr_data,
   input  logic [AW-1:0]               rd_addr,
   output logic [mfp_pkg::VALUE_W-1:0] rd_data
);
   import mfp_pkg::*;

   logic [VALUE_W-1:0] mem [DEPTH];
   logic [VALUE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/mfp_div.sv]
// Restoring divider, one quotient bit per cycle, for the percentage share.
// Depends on mfp_pkg for the status struct.
module mfp_div #(
   parameter int NUM_W = 24,
   parameter int DEN_W = 9
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [NUM_W-1:0]         num,
   input  logic [DEN_W-1:0]         den,   // held stable while busy
   output logic [NUM_W-1:0]         quot,
   output mfp_pkg::div_stat_type    stat
);
   import mfp_pkg::*;

   localparam int STEP_W = $clog2(NUM_W + 1);

   logic [DEN_W-1:0]  rem_ff,  rem_in;
   logic [NUM_W-1:0]  quo_ff,  quo_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DEN_W:0]    trial;
   logic              fits;

   always_comb begin
      trial   = {rem_ff, quo_ff[NUM_W-1]};
      fits    = trial >= {1'b0, den};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = num;
         step_in = STEP_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = fits ? DEN_W'(trial - {1'b0, den}) : DEN_W'(trial);
         quo_in  = {quo_ff[NUM_W-2:0], fits};
         step_in = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign quot      = quo_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

[hdl/mode_finder_with_percentage_core.sv]
// Top level of the mode finder: load sequencer, pairwise scan, result register.
// Depends on mfp_pkg, mfp_store and mfp_div.
//
//   channel  dir  handshake            payload
//   req_     in   req_valid/req_ready  req_item  (value, last)
//   rsp_     out  rsp_valid/rsp_ready  rsp_item  (mode_value, mode_count,
//                                                 percent_q8, overflow)
//
// Loading stores one item per cycle while req_ready is high. On the last item
// the scan runs: for each entry i, S_LOAD latches it, S_CMP compares one later
// entry per cycle and S_TALLY settles its tally; the scan is bounded by the
// single read port of the element store. The divide of the best count * 25600
// by the item count then runs in mfp_div.
// Reset is synchronous, active high, and clears the sequencer, the item count
// and the overflow flag; the store is not cleared (only written entries are
// read). req_ready is high only in S_IDLE, the state in which lists load. A
// finished result waits in the output register; the next list can load while
// it waits, and a new result holds in the last state until that register is free.
module mode_finder_with_percentage_core #(
   parameter int MAX_ITEMS = 256
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  mfp_pkg::req_type req_item,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output mfp_pkg::rsp_type rsp_item
);
   import mfp_pkg::*;

   localparam int AW    = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
   localparam int CW    = $clog2(MAX_ITEMS + 1);   // holds 0..MAX_ITEMS
   localparam int NUM_W = CW + PCT_SCALE_W;

   // sequencer codes
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_FETCH = 4'd1;   // issue read of the first entry
   localparam logic [3:0] S_LOAD  = 4'd2;   // latch candidate, start on later ones
   localparam logic [3:0] S_CMP   = 4'd3;   // one later entry per cycle
   localparam logic [3:0] S_TALLY = 4'd4;   // strict > keeps the earliest on ties
   localparam logic [3:0] S_MUL   = 4'd5;   // count * 25600
   localparam logic [3:0] S_START = 4'd6;
   localparam logic [3:0] S_WAIT  = 4'd7;
   localparam logic [3:0] S_EMIT  = 4'd8;   // wait for a free output register

   logic [3:0]         state_ff, state_in;
   logic [CW-1:0]      cnt_ff,   cnt_in;
   logic               ovf_ff,   ovf_in;
   logic [CW-1:0]      i_ff,     i_in;
   logic [CW-1:0]      j_ff,     j_in;
   logic [CW-1:0]      tally_ff, tally_in;
   logic [CW-1:0]      best_ff,  best_in;
   logic [VALUE_W-1:0] cand_ff,  cand_in;
   logic [VALUE_W-1:0] bval_ff,  bval_in;
   logic [NUM_W-1:0]   num_ff,   num_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff,   rsp_in;

   logic               req_fire;
   logic               store_wr;
   logic [AW-1:0]      rd_addr;
   logic [VALUE_W-1:0] rd_data;
   logic [CW-1:0]      i_nx, j_nx;
   logic               div_start;
   logic [NUM_W-1:0]   div_quot;
   div_stat_type       div_stat;
   logic               slot_free;

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign store_wr  = req_fire && (cnt_ff < CW'(MAX_ITEMS));
   assign i_nx      = i_ff + CW'(1);
   assign j_nx      = j_ff + CW'(1);
   assign slot_free = !rsp_valid_ff || rsp_ready;

   mfp_store #(
      .DEPTH (MAX_ITEMS),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (store_wr),
      .wr_addr (cnt_ff[AW-1:0]),
      .wr_data (req_item.value),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   mfp_div #(
      .NUM_W (NUM_W),
      .DEN_W (CW)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (num_ff),
      .den   (cnt_ff),
      .quot  (div_quot),
      .stat  (div_stat)
   );

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      ovf_in       = ovf_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      tally_in     = tally_ff;
      best_in      = best_ff;
      cand_in      = cand_ff;
      bval_in      = bval_ff;
      num_in       = num_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rd_addr      = i_ff[AW-1:0];
      div_start    = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (store_wr) begin
                  cnt_in = cnt_ff + CW'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_item.last) begin
                  i_in     = '0;
                  best_in  = '0;
                  state_in = S_FETCH;
               end
            end
         end
         S_FETCH: begin
            rd_addr  = i_ff[AW-1:0];
            state_in = S_LOAD;
         end
         S_LOAD: begin
            cand_in  = rd_data;
            tally_in = CW'(1);
            j_in     = i_nx;
            rd_addr  = i_nx[AW-1:0];
            state_in = (i_nx >= cnt_ff) ? S_TALLY : S_CMP;
         end
         S_CMP: begin
            if (rd_data == cand_ff) begin
               tally_in = tally_ff + CW'(1);
            end
            j_in     = j_nx;
            rd_addr  = j_nx[AW-1:0];
            state_in = (j_nx >= cnt_ff) ? S_TALLY : S_CMP;
         end
         S_TALLY: begin
            if (tally_ff > best_ff) begin
               best_in = tally_ff;
               bval_in = cand_ff;
            end
            i_in    = i_nx;
            rd_addr = i_nx[AW-1:0];
            state_in = (i_nx < cnt_ff) ? S_LOAD : S_MUL;
         end
         S_MUL: begin
            num_in   = NUM_W'(best_ff) * NUM_W'(PCT_SCALE_Q8);
            state_in = S_START;
         end
         S_START: begin
            div_start = 1'b1;
            state_in  = S_WAIT;
         end
         S_WAIT: begin
            if (div_stat.done) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (slot_free) begin
               rsp_in.mode_value = bval_ff;
               rsp_in.mode_count = COUNT_W'(best_ff);
               rsp_in.percent_q8 = PCT_W'(div_quot);
               rsp_in.overflow   = ovf_ff;
               rsp_valid_in      = 1'b1;
               cnt_in            = '0;
               ovf_in            = 1'b0;
               state_in          = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      i_ff     <= i_in;
      j_ff     <= j_in;
      tally_ff <= tally_in;
      best_ff  <= best_in;
      cand_ff  <= cand_in;
      bval_ff  <= bval_in;
      num_ff   <= num_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

[bench/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking bench for mode_finder_with_percentage_core: random lists of signed values,
// a shadow mode/percentage calculator, and an in-order check of every result item.
// Depends on mfp_pkg and the core's RTL only.
module tb_top;
   import mfp_pkg::*;

   localparam int MAX_LIST        = 256;         // store capacity of the instance
   localparam int PERCENT_Q8_FULL = 100 << 8;    // 100 % in Q.8
   localparam int RANDOM_ITEMS    = 1450;
   localparam int IDLE_PCT        = 20;
   localparam int CALM_FROM       = 600;         // item window with no idling on either side
   localparam int CALM_TO         = 900;
   localparam int SETTLE_CYCLES   = 200;         // quiet tail after the last result item
   localparam int RUN_LIMIT_NS    = 20_000_000;

   // one list element waiting to be driven; drain holds it back until all
   // outstanding results have come back
   typedef struct {
      req_type item;
      bit      drain;
   } list_elem_type;

   logic    clock;
   logic    reset;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_item  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_item;

   list_elem_type pending_elems_q[$];
   rsp_type       expected_modes_q[$];

   // shadow of the block's list store
   logic signed [VALUE_W-1:0] shadow_store [MAX_LIST];
   int                        shadow_len  = 0;
   bit                        shadow_drop = 1'b0;

   int error_count = 0;
   int sent_count  = 0;
   bit req_taken   = 1'b0;   // item accepted at the last rising edge
   bit calm;

   mode_finder_with_percentage_core #(
      .MAX_ITEMS(MAX_LIST)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_item (req_item),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_item (rsp_item)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   assign calm = (sent_count >= CALM_FROM) && (sent_count < CALM_TO);

   // Adds one element to the shadow list. On the closing item, works out the
   // mode by the same pairwise scan as the block: entry i counts itself plus
   // every equal entry after it, and only a strictly larger tally replaces the
   // best, so the earliest value wins a tie.
   task automatic absorb_element(input req_type e);
      rsp_type                   res;
      int                        best_cnt;
      int                        tally;
      logic signed [VALUE_W-1:0] best_val;
      // store full: the element is dropped, but a closing item still closes
      if (shadow_len < MAX_LIST) begin
         shadow_store[shadow_len] = e.value;
         shadow_len++;
      end else begin
         shadow_drop = 1'b1;
      end
      if (e.last) begin
         best_cnt = 0;
         best_val = '0;
         for (int i = 0; i < shadow_len; i++) begin
            tally = 1;
            for (int j = i + 1; j < shadow_len; j++)
               if (shadow_store[j] == shadow_store[i])
                  tally++;
            if (tally > best_cnt) begin
               best_cnt = tally;
               best_val = shadow_store[i];
            end
         end
         res.mode_value = best_val;
         res.mode_count = best_cnt[COUNT_W-1:0];
         // share of the stored length only, truncated
         res.percent_q8 = PCT_W'((best_cnt * PERCENT_Q8_FULL) / shadow_len);
         res.overflow   = shadow_drop;
         expected_modes_q.push_back(res);
         shadow_len  = 0;
         shadow_drop = 1'b0;
      end
   endtask

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         error_count++;
      end
   endtask

   task automatic queue_elem(input logic [VALUE_W-1:0] v, input bit last, input bit drain);
      list_elem_type le;
      le.item.value = v;
      le.item.last  = last;
      le.drain      = drain;
      pending_elems_q.push_back(le);
   endtask

   // One list of len elements. pool_n == 0: every element fully random;
   // otherwise elements are drawn from pool_n random values so repeats occur.
   task automatic queue_list(input int len, input int pool_n, input bit drain);
      logic [VALUE_W-1:0] pool [MAX_LIST];
      logic [VALUE_W-1:0] v;
      for (int k = 0; k < pool_n; k++) begin
         case ($urandom_range(0, 15))
            0:       pool[k] = 32'h8000_0000;
            1:       pool[k] = 32'h7FFF_FFFF;
            2:       pool[k] = 32'h0000_0000;
            3:       pool[k] = 32'hFFFF_FFFF;
            default: pool[k] = $urandom();
         endcase
      end
      for (int k = 0; k < len; k++) begin
         v = (pool_n == 0) ? $urandom() : pool[$urandom_range(0, pool_n - 1)];
         queue_elem(v, k == len - 1, drain && k == 0);
      end
   endtask

   // Driver: inputs move on the falling edge; an offered item stays put
   // until the rising edge that takes it.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_taken) begin
         req_valid <= 1'b1;
      end else if (pending_elems_q.size() != 0
                   && !(pending_elems_q[0].drain && expected_modes_q.size() != 0)
                   && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
         req_item  <= pending_elems_q[0].item;
         req_valid <= 1'b1;
         void'(pending_elems_q.pop_front());
      end else begin
         req_valid <= 1'b0;
      end
   end

   // result side back-pressure
   always @(negedge clock) begin
      rsp_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
   end

   // Monitor: both channels sampled on the rising edge.
   always @(posedge clock) begin
      req_taken <= !reset && req_valid && req_ready;
      if (!reset) begin
         if (req_valid && req_ready) begin
            sent_count <= sent_count + 1;
            absorb_element(req_item);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_modes_q.size() == 0) begin
               $display("%0t: result item with none expected, actual %0h/%0h/%0h/%0h",
                        $time, rsp_item.mode_value, rsp_item.mode_count,
                        rsp_item.percent_q8, rsp_item.overflow);
               error_count++;
            end else begin
               check_field("mode_value", expected_modes_q[0].mode_value,
                           rsp_item.mode_value);
               check_field("mode_count", expected_modes_q[0].mode_count,
                           rsp_item.mode_count);
               check_field("percent_q8", expected_modes_q[0].percent_q8,
                           rsp_item.percent_q8);
               check_field("overflow", expected_modes_q[0].overflow, rsp_item.overflow);
               void'(expected_modes_q.pop_front());
            end
         end
      end
   end

   initial begin
      int total;
      int big_idx;
      int len;
      int pool_n;
      reset = 1'b1;

      // directed lists
      queue_elem(32'h8000_0000, 1'b1, 1'b0);     // single item, most negative
      queue_elem(32'h7FFF_FFFF, 1'b1, 1'b0);     // single item, most positive
      // two-way tie: 0 listed first must win over -1
      queue_elem(32'h0000_0000, 1'b0, 1'b0);
      queue_elem(32'hFFFF_FFFF, 1'b0, 1'b0);
      queue_elem(32'hFFFF_FFFF, 1'b0, 1'b0);
      queue_elem(32'h0000_0000, 1'b1, 1'b0);
      // later value outnumbers the first one
      queue_elem(32'd5, 1'b0, 1'b0);
      queue_elem(32'd7, 1'b0, 1'b0);
      queue_elem(32'd7, 1'b0, 1'b0);
      queue_elem(32'd7, 1'b0, 1'b0);
      queue_elem(32'd5, 1'b1, 1'b0);
      // all distinct, share 1/3 truncates
      queue_elem(32'h5555_5555, 1'b0, 1'b0);
      queue_elem(32'hAAAA_AAAA, 1'b0, 1'b0);
      queue_elem(32'd3, 1'b1, 1'b0);
      // sign matters: 9 and -9 differ, -9 wins with three
      queue_elem(32'd9, 1'b0, 1'b0);
      queue_elem(-32'sd9, 1'b0, 1'b0);
      queue_elem(32'd9, 1'b0, 1'b0);
      queue_elem(-32'sd9, 1'b0, 1'b0);
      queue_elem(32'd4, 1'b0, 1'b0);
      queue_elem(32'd4, 1'b0, 1'b0);
      queue_elem(-32'sd9, 1'b1, 1'b0);

      // Random lists, mostly short. Three full-size lists sit in between:
      // one value repeated 256 times, one a single item past capacity, and
      // one with several dropped items including the closing one.
      total   = 0;
      big_idx = 0;
      while (total < RANDOM_ITEMS) begin
         if (big_idx < 3 && total >= (big_idx + 1) * 350) begin
            case (big_idx)
               0: begin
                  len    = MAX_LIST;
                  pool_n = 1;
               end
               1: begin
                  len    = MAX_LIST + 1;
                  pool_n = $urandom_range(2, 40);
               end
               default: begin
                  len    = $urandom_range(MAX_LIST + 2, MAX_LIST + 8);
                  pool_n = $urandom_range(100, MAX_LIST);
               end
            endcase
            big_idx++;
         end else begin
            len    = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 16)
                                                  : $urandom_range(17, 64);
            pool_n = ($urandom_range(0, 99) < 25) ? 0 : $urandom_range(1, (len + 1) / 2);
         end
         // first random list always waits for the directed results to drain
         queue_list(len, pool_n, total == 0 || $urandom_range(0, 99) < 5);
         total += len;
      end

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_elems_q.size() != 0 || req_valid)
         @(posedge clock);
      while (expected_modes_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (error_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   initial begin
      #(RUN_LIMIT_NS);
      $display("FAIL");
      $finish;
   end

endmodule
